// ----- hdl/brf_pkg.sv -----
// Shared types and constants for the bisection root finder.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

	localparam int MaxIterationsDef = 48;
	localparam int FractionBitsDef  = 16;

	// configuration register indexes
	typedef enum logic [1:0] {
		RegExponent     = 2'd0,
		RegLinearCoeff  = 2'd1,
		RegConstantTerm = 2'd2,
		RegTolerance    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		StConverged = 2'd0,
		StNoSign    = 2'd1,
		StLimit     = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]         exponent;
		logic signed [15:0] linear_coeff;
		logic signed [31:0] constant_term;
		logic [15:0]        tolerance;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
	} item_t;

	typedef struct packed {
		logic signed [31:0] root;
		status_t            status;
		logic [6:0]         iterations;
	} result_t;

	// evaluator report back to the sequencer
	typedef struct packed {
		logic done;
		logic neg;
		logic zero;
	} eval_res_t;

endpackage

`default_nettype wire

// ----- hdl/brf_eval.sv -----
// Polynomial sign evaluator: x^m + n*x + c, one shared 32x32 multiplier, one sum adder.
`timescale 1ns / 1ps
`default_nettype none

module brf_eval #(
	parameter int FRACTION_BITS = brf_pkg::FractionBitsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] x,
	input  wire brf_pkg::cfg_t      cfg,
	output brf_pkg::eval_res_t      res
);

	localparam int          Shift  = 32 - FRACTION_BITS;
	localparam logic [63:0] Cap    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] CapLim = Cap >> Shift;
	localparam logic [63:0] One    = 64'd1 << FRACTION_BITS;
	localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		S_IDLE, S_HI, S_LO, S_CMB, S_LIN, S_ADD1, S_ADD2
	} state_t;

	state_t      state_q;
	logic        xneg_q;
	logic [31:0] xmag_q;
	logic [63:0] mag_q;
	logic [63:0] p0_q;
	logic [63:0] p1_q;
	logic [63:0] acc_q;
	logic [3:0]  cnt_q;
	logic        done_q;

	logic [31:0] xabs;
	logic [15:0] nabs;
	logic [31:0] mul_a;
	logic [63:0] mul_out;
	logic [64:0] shr_sum;
	logic [63:0] mag_next;
	logic [63:0] pw;
	logic        pw_neg;
	logic [63:0] nx;
	logic [63:0] add_b;
	logic [64:0] add_sum;
	logic [63:0] add_sat;

	assign xabs = x[31] ? (~x + 32'd1) : x;
	assign nabs = cfg.linear_coeff[15] ? (~cfg.linear_coeff + 16'd1) : cfg.linear_coeff;

	always_comb begin
		case (state_q)
			S_HI:    mul_a = mag_q[63:32];
			S_LO:    mul_a = mag_q[31:0];
			default: mul_a = {16'd0, nabs};
		endcase
	end

	assign mul_out = {32'd0, mul_a} * {32'd0, xmag_q};

	// product recombination with saturation at 2^63
	assign shr_sum = {1'b0, p0_q << Shift} + {1'b0, p1_q >> FRACTION_BITS};
	always_comb begin
		if (p0_q > CapLim) begin
			mag_next = Cap;
		end else if (shr_sum > {1'b0, Cap}) begin
			mag_next = Cap;
		end else begin
			mag_next = shr_sum[63:0];
		end
	end

	assign pw_neg = xneg_q & cfg.exponent[0];
	always_comb begin
		if (pw_neg) begin
			pw = mag_q[63] ? Cap : (~mag_q + 64'd1);
		end else begin
			pw = mag_q[63] ? MaxPos : mag_q;
		end
	end

	assign nx = (cfg.linear_coeff[15] ^ xneg_q) ? (~p1_q + 64'd1) : p1_q;

	assign add_b   = (state_q == S_ADD1) ? nx : {{32{cfg.constant_term[31]}}, cfg.constant_term};
	assign add_sum = {acc_q[63], acc_q} + {add_b[63], add_b};
	always_comb begin
		if (add_sum[64] != add_sum[63]) begin
			add_sat = add_sum[64] ? Cap : MaxPos;
		end else begin
			add_sat = add_sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						xneg_q <= x[31];
						xmag_q <= xabs;
						mag_q  <= One;
						cnt_q  <= cfg.exponent;
						state_q <= (cfg.exponent != 4'd0) ? S_HI : S_LIN;
					end
				end
				S_HI: begin
					p0_q    <= mul_out;
					state_q <= S_LO;
				end
				S_LO: begin
					p1_q    <= mul_out;
					state_q <= S_CMB;
				end
				S_CMB: begin
					mag_q   <= mag_next;
					cnt_q   <= cnt_q - 4'd1;
					state_q <= (cnt_q == 4'd1) ? S_LIN : S_HI;
				end
				S_LIN: begin
					p1_q    <= mul_out;
					acc_q   <= pw;
					state_q <= S_ADD1;
				end
				S_ADD1: begin
					acc_q   <= add_sat;
					state_q <= S_ADD2;
				end
				S_ADD2: begin
					acc_q   <= add_sat;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.neg  = acc_q[63];
	assign res.zero = (acc_q == 64'd0);

endmodule

`default_nettype wire

// ----- hdl/bisection_root_finder.sv -----
// Top level: configuration registers, bisection sequencer and result register.
// Sequencing: each evaluation of f runs on the shared multiplier. An item is evaluated at
// both bounds and then at one midpoint per halving; the result is loaded once an exact zero,
// the tolerance or the iteration limit is met, or after the bounds if there is no sign change.
// One item is in work at a time; the next item is taken once the sequencer is back in idle.
// Asynchronous active-low reset returns the sequencer to idle and the configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module bisection_root_finder #(
	parameter int MAX_ITERATIONS = brf_pkg::MaxIterationsDef,
	parameter int FRACTION_BITS  = brf_pkg::FractionBitsDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire brf_pkg::item_t  item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output brf_pkg::result_t     result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [31:0]     cfg_data
);

	typedef enum logic [2:0] {
		T_IDLE, T_EVA, T_EVB, T_MID, T_EVM, T_CHK, T_OUT
	} state_t;

	state_t             state_q;
	brf_pkg::cfg_t      cfg_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic signed [31:0] mid_q;
	logic               fa_neg_q;
	logic               fa_pos_q;
	logic               low_sign_q;
	logic [6:0]         cnt_q;
	brf_pkg::result_t   res_q;
	logic               result_valid_q;
	brf_pkg::result_t   result_q;

	logic               ev_start;
	logic signed [31:0] ev_x;
	brf_pkg::eval_res_t ev;
	logic [32:0]        mid_sum;
	logic signed [31:0] mid;
	logic [32:0]        diff;
	logic [32:0]        dabs;
	logic               fb_neg;
	logic               fb_pos;
	logic               out_free;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != T_IDLE);

	// floor of the exact 33-bit sum halved
	assign mid_sum = {lo_q[31], lo_q} + {hi_q[31], hi_q};
	assign mid     = mid_sum[32:1];

	assign diff = {lo_q[31], lo_q} - {hi_q[31], hi_q};
	assign dabs = diff[32] ? (~diff + 33'd1) : diff;

	assign fb_neg = ev.neg;
	assign fb_pos = !ev.neg && !ev.zero;

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		ev_start = 1'b0;
		ev_x     = item.lower_bound;
		case (state_q)
			T_IDLE: begin
				ev_start = item_valid;
				ev_x     = item.lower_bound;
			end
			T_EVA: begin
				ev_start = ev.done;
				ev_x     = hi_q;
			end
			T_MID: begin
				ev_start = 1'b1;
				ev_x     = mid;
			end
			default: begin
				ev_start = 1'b0;
				ev_x     = mid;
			end
		endcase
	end

	brf_eval #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_eval (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ev_start),
		.x     (ev_x),
		.cfg   (cfg_q),
		.res   (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exponent      <= 4'd1;
			cfg_q.linear_coeff  <= '0;
			cfg_q.constant_term <= '0;
			cfg_q.tolerance     <= 16'd7;
		end else if (cfg_valid && cfg_ready) begin
			case (brf_pkg::reg_index_t'(cfg_index))
				brf_pkg::RegExponent:     cfg_q.exponent      <= cfg_data[3:0];
				brf_pkg::RegLinearCoeff:  cfg_q.linear_coeff  <= cfg_data[15:0];
				brf_pkg::RegConstantTerm: cfg_q.constant_term <= cfg_data;
				brf_pkg::RegTolerance:    cfg_q.tolerance     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			result_valid_q <= 1'b0;
			cnt_q          <= '0;
		end else begin
			if (state_q == T_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (item_valid) begin
						lo_q    <= item.lower_bound;
						hi_q    <= item.upper_bound;
						cnt_q   <= '0;
						state_q <= T_EVA;
					end
				end
				T_EVA: begin
					if (ev.done) begin
						fa_neg_q <= ev.neg;
						fa_pos_q <= !ev.neg && !ev.zero;
						state_q  <= T_EVB;
					end
				end
				T_EVB: begin
					if (ev.done) begin
						if ((fa_neg_q && fb_pos) || (fa_pos_q && fb_neg)) begin
							low_sign_q <= fa_neg_q;
							state_q    <= T_MID;
						end else begin
							res_q.root       <= '0;
							res_q.status     <= brf_pkg::StNoSign;
							res_q.iterations <= '0;
							state_q          <= T_OUT;
						end
					end
				end
				T_MID: begin
					mid_q   <= mid;
					cnt_q   <= cnt_q + 7'd1;
					state_q <= T_EVM;
				end
				T_EVM: begin
					if (ev.done) begin
						if (ev.zero) begin
							res_q.root       <= mid_q;
							res_q.status     <= brf_pkg::StConverged;
							res_q.iterations <= cnt_q;
							state_q          <= T_OUT;
						end else begin
							if (ev.neg != low_sign_q) begin
								hi_q <= mid_q;
							end else begin
								lo_q <= mid_q;
							end
							state_q <= T_CHK;
						end
					end
				end
				T_CHK: begin
					res_q.root       <= mid_q;
					res_q.iterations <= cnt_q;
					if (dabs <= {17'd0, cfg_q.tolerance}) begin
						res_q.status <= brf_pkg::StConverged;
						state_q      <= T_OUT;
					end else if (cnt_q >= 7'(MAX_ITERATIONS)) begin
						res_q.status <= brf_pkg::StLimit;
						state_q      <= T_OUT;
					end else begin
						state_q <= T_MID;
					end
				end
				T_OUT: begin
					if (out_free) begin
						result_q <= res_q;
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
